[src/sorted_read_mark_list_unit_assert.svh]
`ifndef SORTED_READ_MARK_LIST_UNIT_ASSERT_SVH
`define SORTED_READ_MARK_LIST_UNIT_ASSERT_SVH
// Assertion helpers for the read-mark list checker.
`define SRML_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SRML_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

[src/srml_pkg.sv]
package srml_pkg;
    localparam int MaxEntriesDefault = 80;
    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_UNREAD = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_TRUNC = 2'd3;
    localparam logic [1:0] UR_READ = 2'd0;
    localparam logic [1:0] UR_CREATE = 2'd1;
    localparam logic [1:0] UR_MODIFIED = 2'd2;
    localparam logic [1:0] SR_NONE_REC = 2'd0;
    localparam logic [1:0] SR_NOT_FOUND = 2'd1;
    localparam logic [1:0] SR_FOUND = 2'd2;
    localparam logic CFG_EXPIRE = 1'b0;
    localparam logic CFG_ENABLE = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [31:0] create_t;
        logic [31:0] modified_t;
    } t_entry;

    typedef struct packed {
        logic        load;
        logic [1:0]  cmd;
        logic        add_en;
        logic        hit;
        logic [31:0] create_t;
        logic [31:0] modified_t;
    } t_bcast;
endpackage

[src/srml_cell.sv]
module srml_cell
    import srml_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_bcast i_bc,
    input  t_entry i_left,
    input  logic   i_left_gt,
    input  logic   i_first,
    output t_entry o_entry,
    output logic   o_gt,
    output logic   o_eq
);
    t_entry r_e;
    t_entry n_e;
    logic [31:0] w_mod;

    assign o_entry = r_e;
    assign o_gt = !r_e.valid || ($signed(i_bc.create_t) > $signed(r_e.create_t));
    assign o_eq = r_e.valid && (i_bc.create_t == r_e.create_t);

    always_comb begin
        n_e = r_e;
        w_mod = (r_e.modified_t == 32'hFFFF_FFFF) ? 32'd0 : r_e.modified_t;
        if (i_bc.load) begin
            case (i_bc.cmd)
                CMD_TRUNC: begin
                    n_e.valid = i_first;
                    n_e.create_t = i_bc.create_t;
                    n_e.modified_t = i_bc.create_t;
                end
                CMD_ADD: begin
                    if (i_bc.add_en) begin
                        if (o_eq) begin
                            if (i_bc.modified_t != 32'hFFFF_FFFF) begin
                                n_e.modified_t = ($signed(w_mod) < $signed(i_bc.modified_t))
                                    ? i_bc.modified_t : w_mod;
                            end
                        end else if (!i_bc.hit && o_gt && !i_left_gt
                                     && (i_first || r_e.valid)) begin
                            n_e.valid = 1'b1;
                            n_e.create_t = i_bc.create_t;
                            n_e.modified_t = i_bc.modified_t;
                        end else if (!i_bc.hit && o_gt && i_left_gt) begin
                            n_e = i_left;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
        end else begin
            r_e.valid <= n_e.valid;
        end
        r_e.create_t <= n_e.create_t;
        r_e.modified_t <= n_e.modified_t;
    end
endmodule

[src/sorted_read_mark_list_unit.sv]
// An accepted input beat is registered, compared against the cell row while busy, and
// its result beat is then registered onto the outputs. The block takes no new beat
// until the last one is through: the input stalls while an item is compared against
// the cell row and while its result beat waits on an output stall.
// Reset clears the list to empty, expire_time to 0 and user_enabled to 1.
module sorted_read_mark_list_unit
    import srml_pkg::*;
#(
    parameter int MAX_ENTRIES = MaxEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_create_time,
    input  logic [31:0] i_modified_time,
    input  logic        i_search_forward,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_unread_code,
    output logic [1:0]  o_search_code,
    output logic [31:0] o_found_time,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_expire;
    logic        r_enable;
    logic        r_busy;
    logic [1:0]  r_cmd;
    logic [31:0] r_ct;
    logic [31:0] r_mt;
    logic        r_fwd;
    t_bcast      w_bc;
    t_entry      w_e [MAX_ENTRIES];
    logic        w_gt [MAX_ENTRIES];
    logic        w_eq [MAX_ENTRIES];
    logic        w_hit;
    logic        w_acc;
    logic        w_expired;
    logic [1:0]  n_ucode;
    logic [1:0]  n_scode;
    logic [31:0] n_found;

    assign o_cfg_ready = 1'b1;
    assign o_stall = r_busy || o_valid;
    assign w_acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expire <= 32'd0;
            r_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_EXPIRE) begin
                r_expire <= i_cfg_data;
            end else begin
                r_enable <= i_cfg_data[0];
            end
        end
    end

    always_comb begin
        w_hit = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_hit = w_hit | w_eq[i];
        end
    end

    assign w_expired = !($signed(r_ct) > $signed(r_expire));
    assign w_bc.load = r_busy;
    assign w_bc.cmd = r_cmd;
    assign w_bc.add_en = r_enable && !w_expired;
    assign w_bc.hit = w_hit;
    assign w_bc.create_t = r_ct;
    assign w_bc.modified_t = r_mt;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        srml_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_bc     (w_bc),
            .i_left   ((g == 0) ? '0 : w_e[(g == 0) ? 0 : g - 1]),
            .i_left_gt((g == 0) ? 1'b0 : w_gt[(g == 0) ? 0 : g - 1]),
            .i_first  (g == 0),
            .o_entry  (w_e[g]),
            .o_gt     (w_gt[g]),
            .o_eq     (w_eq[g])
        );
    end

    always_comb begin
        logic done;
        logic [31:0] sm;
        done = 1'b0;
        sm = 32'd0;
        n_ucode = UR_READ;
        n_scode = SR_NONE_REC;
        n_found = 32'd0;
        if (r_cmd == CMD_UNREAD) begin
            if (w_expired) begin
                n_ucode = UR_READ;
            end else if (!w_e[0].valid) begin
                n_ucode = UR_CREATE;
            end else begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (!done && w_e[i].valid) begin
                        if (w_gt[i]) begin
                            n_ucode = UR_CREATE;
                            done = 1'b1;
                        end else if (w_eq[i]) begin
                            sm = w_e[i].modified_t;
                            done = 1'b1;
                            if (r_mt != 32'd0 && sm != 32'd0 && r_mt != 32'hFFFF_FFFF
                                && sm != 32'hFFFF_FFFF && $signed(r_mt) > $signed(sm)) begin
                                n_ucode = UR_MODIFIED;
                            end
                        end
                    end
                end
            end
        end else if (r_cmd == CMD_SEARCH) begin
            if (!w_e[0].valid || (!w_e[1].valid && w_e[0].create_t == 32'd1)) begin
                n_scode = SR_NONE_REC;
            end else begin
                n_scode = SR_NOT_FOUND;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (!done && (w_gt[i] || w_eq[i])) begin
                        done = 1'b1;
                        if (!w_e[i].valid) begin
                            if (r_fwd) begin
                                n_scode = SR_FOUND;
                                n_found = w_e[(i == 0) ? 0 : i - 1].create_t;
                            end
                        end else if (w_gt[i]) begin
                            if (!r_fwd) begin
                                n_scode = SR_FOUND;
                                n_found = w_e[i].create_t;
                            end else if (i > 0) begin
                                n_scode = SR_FOUND;
                                n_found = w_e[(i == 0) ? 0 : i - 1].create_t;
                            end
                        end else begin
                            if (r_fwd && i > 0) begin
                                n_scode = SR_FOUND;
                                n_found = w_e[(i == 0) ? 0 : i - 1].create_t;
                            end else if (!r_fwd && i + 1 < MAX_ENTRIES
                                         && w_e[(i + 1 < MAX_ENTRIES) ? i + 1 : i].valid) begin
                                n_scode = SR_FOUND;
                                n_found = w_e[(i + 1 < MAX_ENTRIES) ? i + 1 : i].create_t;
                            end
                        end
                    end
                end
                if (!done && r_fwd) begin
                    n_scode = SR_FOUND;
                    n_found = w_e[MAX_ENTRIES - 1].create_t;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            if (w_acc) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                o_valid <= 1'b1;
            end
        end
        if (w_acc) begin
            r_cmd <= i_cmd;
            r_ct <= i_create_time;
            r_mt <= i_modified_time;
            r_fwd <= i_search_forward;
        end
        if (r_busy) begin
            o_unread_code <= n_ucode;
            o_search_code <= n_scode;
            o_found_time <= n_found;
        end
    end
endmodule

[src/srml_checker.sv]
`include "sorted_read_mark_list_unit_assert.svh"
module srml_checker
    import srml_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_unread_code,
    input logic [1:0] o_search_code
);
    logic w_one_code;

    assign w_one_code = (o_unread_code == UR_READ) || (o_search_code == SR_NONE_REC);

    `SRML_ASSERT(a_no_accept_while_out, i_clk, i_rst_n, o_valid |-> o_stall)
    `SRML_ASSERT(a_one_result, i_clk, i_rst_n, (i_valid && !o_stall) |=> ##1 o_valid)
    `SRML_ASSERT(a_codes_excl, i_clk, i_rst_n, o_valid |-> w_one_code)
    `SRML_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !o_valid)
endmodule

bind sorted_read_mark_list_unit srml_checker u_srml_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_unread_code(o_unread_code),
    .o_search_code(o_search_code)
);

[verif/tb_sorted_read_mark_list_unit.sv]
`timescale 1ns / 100ps

module tb_sorted_read_mark_list_unit;
    import srml_pkg::*;

    localparam int LIST_DEPTH = MaxEntriesDefault;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  unread_code;
        logic [1:0]  search_code;
        logic [31:0] found_time;
    } mark_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_cmd;
    logic [31:0] i_create_time;
    logic [31:0] i_modified_time;
    logic        i_search_forward;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_unread_code;
    logic [1:0]  o_search_code;
    logic [31:0] o_found_time;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    sorted_read_mark_list_unit dut (.*);

    int unsigned mark_create [LIST_DEPTH];
    int          mark_modified [LIST_DEPTH];
    int          mark_count;
    int          expire_limit;
    bit          adds_enabled;

    mark_result_t pending_results[$];
    int  error_count;
    int  cycle_count;
    bit  quiet_mode;
    bit  hold_rx;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int ct_at(int idx);
        return int'(mark_create[idx]);
    endfunction

    function automatic void apply_add(int ct, int mt);
        int n;
        if (!adds_enabled || ct <= expire_limit) return;
        if (mark_count == 0) begin
            mark_create[0] = ct;
            mark_modified[0] = mt;
            mark_count = 1;
            return;
        end
        if (mark_count == 1 && ct < ct_at(0)) return;
        for (n = 0; n < mark_count; n++) begin
            if (ct == ct_at(n)) begin
                if (mt == -1) return;
                if (mark_modified[n] == -1) mark_modified[n] = 0;
                if (mark_modified[n] < mt) mark_modified[n] = mt;
                return;
            end
            if (ct > ct_at(n)) begin
                if (mark_count < LIST_DEPTH) mark_count++;
                for (int i = mark_count - 2; i >= n; i--) begin
                    mark_create[i + 1] = mark_create[i];
                    mark_modified[i + 1] = mark_modified[i];
                end
                mark_create[n] = ct;
                mark_modified[n] = mt;
                return;
            end
        end
    endfunction

    function automatic logic [1:0] classify_unread(int ct, int mt);
        if (ct <= expire_limit) return UR_READ;
        if (mark_count == 0) return UR_CREATE;
        for (int i = 0; i < mark_count; i++) begin
            if (ct > ct_at(i)) return UR_CREATE;
            if (ct == ct_at(i)) begin
                if (mt == 0 || mark_modified[i] == 0) return UR_READ;
                if (mt == -1 || mark_modified[i] == -1) return UR_READ;
                return (mt > mark_modified[i]) ? UR_MODIFIED : UR_READ;
            end
        end
        return UR_READ;
    endfunction

    function automatic mark_result_t find_neighbor(int ct, bit fwd);
        mark_result_t r;
        int i;
        r = '0;
        r.search_code = SR_NOT_FOUND;
        if (mark_count == 0 || (mark_count == 1 && ct_at(0) == 1)) begin
            r.search_code = SR_NONE_REC;
            return r;
        end
        for (i = 0; i < mark_count; i++) begin
            if (ct > ct_at(i)) begin
                if (fwd) begin
                    if (i == 0) return r;
                    r.found_time = mark_create[i - 1];
                end else begin
                    r.found_time = mark_create[i];
                end
                r.search_code = SR_FOUND;
                return r;
            end
            if (ct == ct_at(i)) begin
                if (fwd && i > 0) begin
                    r.found_time = mark_create[i - 1];
                    r.search_code = SR_FOUND;
                end else if (!fwd && i + 1 < mark_count) begin
                    r.found_time = mark_create[i + 1];
                    r.search_code = SR_FOUND;
                end
                return r;
            end
        end
        if (fwd && i > 0) begin
            r.found_time = mark_create[i - 1];
            r.search_code = SR_FOUND;
        end
        return r;
    endfunction

    function automatic mark_result_t predict_mark(logic [1:0] cmd, int ct, int mt, bit fwd);
        mark_result_t r;
        r = '0;
        case (cmd)
            CMD_ADD: apply_add(ct, mt);
            CMD_UNREAD: r.unread_code = classify_unread(ct, mt);
            CMD_SEARCH: r = find_neighbor(ct, fwd);
            default: begin
                mark_create[0] = ct;
                mark_modified[0] = ct;
                mark_count = 1;
            end
        endcase
        return r;
    endfunction

    task automatic send_beat(logic [1:0] cmd, int ct, int mt, bit fwd);
        if (!quiet_mode && $urandom_range(99) < 6) begin
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_cmd = cmd;
        i_create_time = ct;
        i_modified_time = mt;
        i_search_forward = fwd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_mark(cmd, ct, mt, fwd));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_EXPIRE) expire_limit = data;
        else adds_enabled = data[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_rx) i_stall <= 1'b1;
        else i_stall <= !quiet_mode && ($urandom_range(99) < 6);
    end

    always @(posedge i_clk) begin
        mark_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat", $time);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_unread_code !== want.unread_code) begin
                    $display("%0t: unread_code exp %0d got %0d", $time,
                             want.unread_code, o_unread_code);
                    error_count++;
                end
                if (o_search_code !== want.search_code) begin
                    $display("%0t: search_code exp %0d got %0d", $time,
                             want.search_code, o_search_code);
                    error_count++;
                end
                if (o_found_time !== want.found_time) begin
                    $display("%0t: found_time exp %0d got %0d", $time,
                             $signed(want.found_time), $signed(o_found_time));
                    error_count++;
                end
            end
        end
    end

    function automatic int near_time(int base);
        return base + int'($urandom_range(0, 40)) - 20;
    endfunction

    function automatic int pick_time();
        case ($urandom_range(9))
            0: return int'($urandom());
            1: return 32'h7fffffff - $urandom_range(3);
            2: return 32'h80000000 + $urandom_range(3);
            3: return -1;
            default: return near_time(1000);
        endcase
    endfunction

    task automatic test_directed();
        send_beat(CMD_SEARCH, 5, 0, 1'b1);
        send_beat(CMD_UNREAD, 5, 0, 1'b0);
        send_beat(CMD_ADD, 0, 7, 1'b0);
        send_beat(CMD_ADD, 100, 50, 1'b0);
        send_beat(CMD_ADD, 50, 9, 1'b0);
        send_beat(CMD_ADD, 200, -1, 1'b0);
        send_beat(CMD_ADD, 200, 5, 1'b0);
        send_beat(CMD_ADD, 200, -1, 1'b0);
        send_beat(CMD_ADD, 100, 30, 1'b0);
        send_beat(CMD_ADD, 150, 60, 1'b1);
        send_beat(CMD_UNREAD, 100, 70, 1'b0);
        send_beat(CMD_UNREAD, 200, 0, 1'b0);
        send_beat(CMD_UNREAD, 300, 3, 1'b0);
        send_beat(CMD_SEARCH, 300, 0, 1'b1);
        send_beat(CMD_SEARCH, 150, 0, 1'b1);
        send_beat(CMD_SEARCH, 150, 0, 1'b0);
        send_beat(CMD_SEARCH, 1, 0, 1'b1);
        send_beat(CMD_SEARCH, 1, 0, 1'b0);
        send_beat(CMD_ADD, 32'h7fffffff, 32'h7fffffff, 1'b1);
        send_beat(CMD_TRUNC, 1, 0, 1'b0);
        send_beat(CMD_SEARCH, 1, 0, 1'b0);
        send_beat(CMD_TRUNC, 32'h80000000, 32'hffffffff, 1'b1);
        send_beat(CMD_UNREAD, 32'h80000000, 32'hffffffff, 1'b1);
    endtask

    task automatic test_fill_overflow();
        send_beat(CMD_TRUNC, 10, 0, 1'b0);
        for (int k = 0; k < LIST_DEPTH + 10; k++)
            send_beat(CMD_ADD, 20 + 3 * k, k, 1'b0);
        send_beat(CMD_ADD, 11, 0, 1'b0);
        send_beat(CMD_SEARCH, 0, 0, 1'b1);
        send_beat(CMD_SEARCH, 40000, 0, 1'b0);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (60) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            for (int k = 0; k < 20; k++)
                send_beat(2'($urandom_range(3)), near_time(1000), near_time(5), $urandom_range(1));
        join
    endtask

    task automatic run_random(int count);
        logic [1:0] cmd;
        int ct;
        for (int k = 0; k < count; k++) begin
            quiet_mode = (k % 300) > 220;
            cmd = 2'($urandom_range(3));
            if (cmd == CMD_TRUNC && $urandom_range(9) != 0) cmd = CMD_ADD;
            if ($urandom_range(2) == 0 && mark_count > 0)
                ct = ct_at($urandom_range(mark_count - 1));
            else
                ct = pick_time();
            send_beat(cmd, ct, pick_time(), $urandom_range(1));
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_ENABLE, 32'd0);
        send_beat(CMD_ADD, 5000, 1, 1'b0);
        send_beat(CMD_TRUNC, 900, 0, 1'b0);
        run_random(150);
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_EXPIRE, 32'd995);
        run_random(300);
        write_reg(CFG_EXPIRE, 32'h7fffffff);
        run_random(60);
        write_reg(CFG_EXPIRE, 32'h80000000);
        run_random(300);
        write_reg(CFG_EXPIRE, 32'hffffffff);
        run_random(200);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cmd = CMD_ADD;
        i_create_time = '0;
        i_modified_time = '0;
        i_search_forward = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_EXPIRE;
        i_cfg_data = '0;
        cycle_count = 0;
        error_count = 0;
        quiet_mode = 1'b0;
        hold_rx = 1'b0;
        mark_count = 0;
        expire_limit = 0;
        adds_enabled = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_fill_overflow();
        test_backpressure();
        run_random(200);
        test_config_sweep();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+src
src/srml_pkg.sv
src/srml_cell.sv
src/sorted_read_mark_list_unit.sv
src/srml_checker.sv
verif/tb_sorted_read_mark_list_unit.sv
